/* rtl/core/trir_pkg.sv */
// ----------------------------------------------------------------------------
// trir_pkg
// shared types, constants and the generator step for the random-in-range core
// ----------------------------------------------------------------------------
package trir_pkg;

    localparam int BOUND_W  = 16;
    localparam int VALUE_W  = 16;
    localparam int RAW_W    = 31;
    localparam int COMP_W   = 32;
    localparam int SPAN_W   = BOUND_W + 1;
    localparam int STEPS    = RAW_W;
    localparam int STEP_W   = $clog2(STEPS);

    localparam logic [COMP_W-1:0] COMP_SEED   = 32'd12345;
    localparam logic [COMP_W-1:0] MASK_ONE    = 32'd4294967294;
    localparam logic [COMP_W-1:0] MASK_TWO    = 32'd4294967288;
    localparam logic [COMP_W-1:0] MASK_THREE  = 32'd4294967280;
    localparam logic [COMP_W-1:0] MASK_FOUR   = 32'd4294967168;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } trir_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } trir_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } trir_status_t;

    typedef struct packed {
        logic [COMP_W-1:0] one;
        logic [COMP_W-1:0] two;
        logic [COMP_W-1:0] three;
        logic [COMP_W-1:0] four;
    } trir_comps_t;

    function automatic trir_comps_t taus_advance(input trir_comps_t z);
        trir_comps_t       n;
        logic [COMP_W-1:0] t;
        t       = ((z.one << 6) ^ z.one) >> 13;
        n.one   = ((z.one & MASK_ONE) << 18) ^ t;
        t       = ((z.two << 2) ^ z.two) >> 27;
        n.two   = ((z.two & MASK_TWO) << 2) ^ t;
        t       = ((z.three << 13) ^ z.three) >> 21;
        n.three = ((z.three & MASK_THREE) << 7) ^ t;
        t       = ((z.four << 3) ^ z.four) >> 12;
        n.four  = ((z.four & MASK_FOUR) << 13) ^ t;
        return n;
    endfunction

endpackage

/* rtl/core/trir_req_if.sv */
// ----------------------------------------------------------------------------
// trir_req_if
// request channel: two signed bounds with valid/ready
// ----------------------------------------------------------------------------
interface trir_req_if
    import trir_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [BOUND_W-1:0]  bound_a;
    logic signed [BOUND_W-1:0]  bound_b;

    modport source (output valid, output bound_a, output bound_b, input ready);
    modport sink   (input valid, input bound_a, input bound_b, output ready);
endinterface

/* rtl/core/trir_rsp_if.sv */
// ----------------------------------------------------------------------------
// trir_rsp_if
// result channel: ranged value and raw generator word with valid/ready
// ----------------------------------------------------------------------------
interface trir_rsp_if
    import trir_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  value;
    logic        [RAW_W-1:0]    raw;

    modport source (output valid, output value, output raw, input ready);
    modport sink   (input valid, input value, input raw, output ready);
endinterface

/* rtl/core/trir_ctrl.sv */
// ----------------------------------------------------------------------------
// trir_ctrl
// sequencer: accept, 31 remainder steps, hand result to output register
// ----------------------------------------------------------------------------
module trir_ctrl
    import trir_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  trir_status_t status,
    output trir_cmd_t    cmd
);

    trir_state_t        state_reg, state_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DIVIDE:
            begin
                cmd.step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/core/trir_datapath.sv */
// ----------------------------------------------------------------------------
// trir_datapath
// generator words, bound ordering, restoring remainder and output register
// ----------------------------------------------------------------------------
module trir_datapath
    import trir_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  trir_cmd_t                  cmd,
    output trir_status_t               status,
    input  logic signed [BOUND_W-1:0]  bound_a,
    input  logic signed [BOUND_W-1:0]  bound_b,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [VALUE_W-1:0]  out_value,
    output logic        [RAW_W-1:0]    out_raw
);

    trir_comps_t               comps_reg;
    trir_comps_t               comps_adv;
    logic signed [BOUND_W-1:0] lo_reg;
    logic        [SPAN_W-1:0]  span_reg;
    logic        [RAW_W-1:0]   raw_reg;
    logic        [RAW_W-1:0]   shift_reg;
    logic        [SPAN_W-1:0]  rem_reg;
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic        [RAW_W-1:0]   out_raw_reg;

    logic signed [BOUND_W-1:0] lo_sel, hi_sel;
    logic        [SPAN_W-1:0]  span_next;
    logic        [COMP_W-1:0]  mix;
    logic        [SPAN_W:0]    trial;
    logic        [SPAN_W:0]    diff;
    logic        [SPAN_W-1:0]  rem_next;

    assign comps_adv = taus_advance(comps_reg);
    assign mix       = comps_adv.one ^ comps_adv.two ^ comps_adv.three ^ comps_adv.four;

    // order the bounds, span = hi - lo + 1 in 1..65536
    always_comb
    begin
        if (bound_b < bound_a)
        begin
            lo_sel = bound_b;
            hi_sel = bound_a;
        end
        else
        begin
            lo_sel = bound_a;
            hi_sel = bound_b;
        end
        span_next = SPAN_W'({hi_sel[BOUND_W-1], hi_sel})
                  - SPAN_W'({lo_sel[BOUND_W-1], lo_sel})
                  + SPAN_W'(1);
    end

    // one restoring step: bring in next raw bit, subtract span if it fits
    always_comb
    begin
        trial = {rem_reg, shift_reg[RAW_W-1]};
        diff  = trial - {1'b0, span_reg};
        if (!diff[SPAN_W])
        begin
            rem_next = diff[SPAN_W-1:0];
        end
        else
        begin
            rem_next = trial[SPAN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comps_reg     <= '{one: COMP_SEED, two: COMP_SEED,
                               three: COMP_SEED, four: COMP_SEED};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                comps_reg <= comps_adv;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lo_reg    <= lo_sel;
            span_reg  <= span_next;
            raw_reg   <= mix[COMP_W-1:1];
            shift_reg <= mix[COMP_W-1:1];
            rem_reg   <= '0;
        end
        else if (cmd.step)
        begin
            rem_reg   <= rem_next;
            shift_reg <= {shift_reg[RAW_W-2:0], 1'b0};
        end
        if (cmd.emit)
        begin
            out_value_reg <= lo_reg + $signed(rem_reg[VALUE_W-1:0]);
            out_raw_reg   <= raw_reg;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_value       = out_value_reg;
    assign out_raw         = out_raw_reg;

endmodule

/* rtl/core/tausworthe_random_in_range_core.sv */
// ----------------------------------------------------------------------------
// tausworthe_random_in_range_core
// combined four-word tausworthe generator with reduction into a signed range
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                         | transfer when
//  --------+-----+---------------------------------+---------------------
//  req     | in  | bound_a, bound_b (s16)          | req.valid & req.ready
//  rsp     | out | value (s16), raw (u31)          | rsp.valid & rsp.ready
//
//  a request is accepted, then 31 restoring remainder steps run
//  (one raw bit per cycle in the datapath), then the result is loaded into the output register
//  req.ready is high only while the sequencer is idle; a new request is taken
//  while an earlier result still waits in the output register
//  a stalled result holds the sequencer in its finish step until rsp drains
//  reset loads all four generator words with 12345 and empties the output
//
module tausworthe_random_in_range_core
    import trir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    trir_req_if.sink    req,
    trir_rsp_if.source  rsp
);

    trir_cmd_t    cmd;
    trir_status_t status;

    // sequencer: owns the step count and the handshake on the request side
    trir_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: generator advances once per accepted request, the raw word
    // is reduced modulo the span bit by bit, then lo is added back
    trir_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .bound_a   (req.bound_a),
        .bound_b   (req.bound_b),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_value (rsp.value),
        .out_raw   (rsp.raw)
    );

endmodule

/* bench/tausworthe_random_in_range_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tausworthe_random_in_range_core_test
// self-checking bench: directed and random bound pairs against a local
// four-word tausworthe predictor, with random idling on both channels
// ----------------------------------------------------------------------------
module tausworthe_random_in_range_core_test;
    import trir_pkg::*;

    // bench timing
    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_ITEMS  = 1130;
    localparam int DRAIN_CYCLES  = 64;    // quiet stretch after the last result, watching for strays
    localparam int QUIET_LIMIT   = 1000;  // cycles with no transfer on either side

    // one pending request and the idle cycles the sender inserts after it
    typedef struct {
        logic signed [BOUND_W-1:0] bound_a;
        logic signed [BOUND_W-1:0] bound_b;
        int unsigned               gap;
    } bound_req_t;

    // one expected result
    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic        [RAW_W-1:0]   raw;
    } ranged_draw_t;

    logic clk = 1'b0;
    logic rst_n;

    trir_req_if req ();
    trir_rsp_if rsp ();

    tausworthe_random_in_range_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor: the four generator words and the range reduction
    // ------------------------------------------------------------------------

    // per-word shift amounts and masks of the combined generator
    localparam int          PRE_SHIFT  [4] = '{6, 2, 13, 3};
    localparam int          FOLD_SHIFT [4] = '{13, 27, 21, 12};
    localparam int          KEEP_SHIFT [4] = '{18, 2, 7, 13};
    localparam logic [31:0] KEEP_MASK  [4] = '{MASK_ONE, MASK_TWO, MASK_THREE, MASK_FOUR};

    logic [COMP_W-1:0] gen_word [4];
    ranged_draw_t      draws_due [$];
    bound_req_t        pending_reqs [$];
    int                error_count = 0;

    function automatic logic [COMP_W-1:0] shift_word(input logic [COMP_W-1:0] w, input int k);
        logic [COMP_W-1:0] feedback;
        feedback = ((w << PRE_SHIFT[k]) ^ w) >> FOLD_SHIFT[k];
        return ((w & KEEP_MASK[k]) << KEEP_SHIFT[k]) ^ feedback;
    endfunction

    // advance the generator once and queue the ranged draw for this bound pair
    task automatic predict_draw(input logic signed [BOUND_W-1:0] a,
                                input logic signed [BOUND_W-1:0] b);
        int            lo;
        int            hi;
        logic [31:0]   span;
        logic [31:0]   mixed;
        ranged_draw_t  d;
        lo = (a < b) ? int'(a) : int'(b);
        hi = (a < b) ? int'(b) : int'(a);
        span = 32'(hi - lo + 1);
        for (int k = 0; k < 4; k++)
        begin
            gen_word[k] = shift_word(gen_word[k], k);
        end
        mixed   = (gen_word[0] ^ gen_word[1] ^ gen_word[2] ^ gen_word[3]) >> 1;
        d.raw   = mixed[RAW_W-1:0];
        d.value = VALUE_W'(lo + int'(mixed % span));
        draws_due.push_back(d);
    endtask

    // ------------------------------------------------------------------------
    // request driver: presents queued bound pairs, idles between them
    // ------------------------------------------------------------------------
    int unsigned req_wait;
    bound_req_t  next_req;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid   <= 1'b0;
            req.bound_a <= '0;
            req.bound_b <= '0;
            req_wait     = 0;
            for (int k = 0; k < 4; k++)
            begin
                gen_word[k] = COMP_SEED;
            end
        end
        else
        begin
            // a transfer advances the generator in the predictor too
            if (req.valid && req.ready)
            begin
                predict_draw(req.bound_a, req.bound_b);
            end
            // a new item may go out once the current one is taken
            if (!req.valid || req.ready)
            begin
                if (req_wait != 0)
                begin
                    req.valid <= 1'b0;
                    req_wait   = req_wait - 1;
                end
                else if (pending_reqs.size() != 0)
                begin
                    next_req     = pending_reqs.pop_front();
                    req.valid   <= 1'b1;
                    req.bound_a <= next_req.bound_a;
                    req.bound_b <= next_req.bound_b;
                    req_wait     = next_req.gap;
                end
                else
                begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: stalls at random and checks each transfer in order
    // ------------------------------------------------------------------------
    int unsigned  rsp_hold;
    logic         rsp_calm;
    ranged_draw_t due;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rsp_hold   = 0;
            rsp_calm   = 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (draws_due.size() == 0)
                begin
                    $error("unexpected result: value %0d raw 0x%08h", rsp.value, rsp.raw);
                    error_count++;
                end
                else
                begin
                    due = draws_due.pop_front();
                    if (rsp.value !== due.value)
                    begin
                        $error("value: expected %0d, actual %0d", due.value, rsp.value);
                        error_count++;
                    end
                    if (rsp.raw !== due.raw)
                    begin
                        $error("raw: expected 0x%08h, actual 0x%08h", due.raw, rsp.raw);
                        error_count++;
                    end
                end
                // now and then switch between stalling and a no-stall stretch
                if ($urandom_range(0, 39) == 0)
                begin
                    rsp_calm = !rsp_calm;
                end
                rsp_hold = rsp_calm ? 0 : $urandom_range(0, 7);
            end
            else if (rsp_hold != 0)
            begin
                rsp_hold = rsp_hold - 1;
            end
            rsp.ready <= (rsp_hold == 0);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: a hung handshake on either side ends the run
    // ------------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles + 1 >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    logic sender_calm = 1'b0;

    task automatic queue_bounds(input int a, input int b);
        bound_req_t r;
        r.bound_a = BOUND_W'(a);
        r.bound_b = BOUND_W'(b);
        r.gap     = sender_calm ? 0 : $urandom_range(0, 7);
        pending_reqs.push_back(r);
    endtask

    initial
    begin
        int lo_i;
        int hi_i;
        int size_i;

        // hold reset while the stimulus is built
        rst_n = 1'b0;

        // directed: full range both ways round, equal bounds, extremes,
        // reversed pairs, alternating bit patterns
        queue_bounds(-32768, 32767);
        queue_bounds(32767, -32768);
        queue_bounds(0, 0);
        queue_bounds(-32768, -32768);
        queue_bounds(32767, 32767);
        queue_bounds(-1, -1);
        queue_bounds(5, -5);
        queue_bounds(-5, 5);
        queue_bounds(0, 1);
        queue_bounds(1, 0);
        queue_bounds(-1, 0);
        queue_bounds(-32768, -32767);
        queue_bounds(32767, 32766);
        queue_bounds(21845, -21846);
        queue_bounds(-21846, 21845);
        queue_bounds(0, 32767);
        queue_bounds(-32768, 0);
        queue_bounds(-1, 32767);
        queue_bounds(1234, -4321);
        queue_bounds(-32768, 32766);

        // random: mostly arbitrary pairs, plus narrow, equal and
        // power-of-two wide ranges to exercise every remainder width
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                sender_calm = ($urandom_range(0, 2) == 0);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    queue_bounds($urandom_range(0, 65535), $urandom_range(0, 65535));
                end
                4, 5:
                begin
                    lo_i = int'($signed(BOUND_W'($urandom_range(0, 65535))));
                    hi_i = lo_i + $urandom_range(0, 15);
                    if (hi_i > 32767)
                    begin
                        hi_i = 32767;
                    end
                    if ($urandom_range(0, 1) == 0)
                        queue_bounds(lo_i, hi_i);
                    else
                        queue_bounds(hi_i, lo_i);
                end
                6:
                begin
                    lo_i = $urandom_range(0, 65535);
                    queue_bounds(lo_i, lo_i);
                end
                7, 8:
                begin
                    size_i = 1 << $urandom_range(0, 16);
                    lo_i   = -32768 + $urandom_range(0, 65536 - size_i);
                    hi_i   = lo_i + size_i - 1;
                    if ($urandom_range(0, 1) == 0)
                        queue_bounds(lo_i, hi_i);
                    else
                        queue_bounds(hi_i, lo_i);
                end
                default:
                begin
                    // one bound pinned at an end of the field
                    lo_i = $urandom_range(0, 1) ? -32768 : 32767;
                    queue_bounds(lo_i, $urandom_range(0, 65535));
                end
            endcase
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every request taken and every result back, then watch for strays
        @(negedge clk);
        while (pending_reqs.size() != 0 || req.valid || draws_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
